// ----- rtl/spi_card_sector_transfer_assert.svh -----
// Assertion macros for the SPI card sector transfer block
`ifndef SPI_CARD_SECTOR_TRANSFER_ASSERT_SVH
`define SPI_CARD_SECTOR_TRANSFER_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define SCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define SCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/scs_pkg.sv -----
// Shared types and constants of the SPI card sector transfer block
package scs_pkg;

  localparam logic [7:0] ByteIdle    = 8'hFF;
  localparam logic [7:0] TokenStart  = 8'hFE;
  localparam logic [7:0] CmdFlag     = 8'h40;
  localparam logic [7:0] CmdCrc      = 8'h95;
  localparam logic [7:0] CmdRead     = 8'd17;
  localparam logic [7:0] CmdWrite    = 8'd24;
  localparam logic [7:0] R1Ready     = 8'h00;
  localparam logic [7:0] DrespMask   = 8'h1F;
  localparam logic [7:0] DrespOk     = 8'h05;

  localparam logic [31:0] NacLimitRst   = 32'd500;
  localparam logic [7:0]  PollLimitRst  = 8'd255;
  localparam logic [7:0]  ResendLimitRst = 8'd255;
  localparam logic [3:0]  RetryLimitRst = 4'd10;

  typedef enum logic [1:0] {
    CfgNacLimit    = 2'd0,
    CfgPollLimit   = 2'd1,
    CfgResendLimit = 2'd2,
    CfgRetryLimit  = 2'd3
  } scs_cfg_idx_e;

  typedef enum logic [1:0] {
    StOk           = 2'd0,
    StCmdFail      = 2'd1,
    StTokenTimeout = 2'd2,
    StWriteReject  = 2'd3
  } scs_status_e;

  typedef struct packed {
    logic [31:0] nac_limit;
    logic [7:0]  poll_limit;
    logic [7:0]  resend_limit;
    logic [3:0]  retry_limit;
  } scs_cfg_t;

  typedef struct packed {
    logic        kind;
    logic        write_op;
    logic [22:0] sector;
    logic [8:0]  offset;
    logic [9:0]  count;
    logic [7:0]  miso;
    logic [7:0]  wdata;
  } scs_item_t;

  typedef struct packed {
    logic [7:0]  mosi;
    logic        cs_active;
    logic [7:0]  rdata;
    logic        rdata_valid;
    logic        wdata_taken;
    logic        done_res;
    scs_status_e status;
  } scs_res_t;

endpackage

// ----- rtl/spi_card_sector_transfer.sv -----
// A result passes the input register and then the result register. Throughput: one
// item per cycle while m_axis_tready is high; input and result registers decouple
// the stream sides, so a new item is taken while a finished result waits for m_axis_tready.
// The per-item work is one pass of the sequencer logic between the two registers.
// Reset (rst_ni low, asynchronous): both stages empty, sequencer idle, counters zero,
// limits back to nac 500, poll 255, resend 255, retries 10.
`include "spi_card_sector_transfer_assert.svh"

module spi_card_sector_transfer import scs_pkg::*; #(
  parameter int SECTOR_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request / exchange stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] write_op, [23:1] sector, [32:24] offset, [42:33] count,
  // [50:43] miso, [58:51] wdata, [63:59] zero
  input  logic [63:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] mosi, [8] cs_active, [16:9] rdata, [17] rdata_valid,
  // [18] wdata_taken, [20:19] status, [23:21] zero
  output logic [23:0] m_axis_tdata,
  // done_res: last result of a transfer
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  scs_cfg_t  cfg;
  scs_item_t in_q;
  logic      in_valid_q, in_valid_d;
  scs_res_t  res, out_q;
  logic      out_valid_q, out_valid_d;
  logic      take, adv;

  // item moves into the result register when it is free or being drained
  assign adv  = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.kind     <= s_axis_tuser;
      in_q.write_op <= s_axis_tdata[0];
      in_q.sector   <= s_axis_tdata[23:1];
      in_q.offset   <= s_axis_tdata[32:24];
      in_q.count    <= s_axis_tdata[42:33];
      in_q.miso     <= s_axis_tdata[50:43];
      in_q.wdata    <= s_axis_tdata[58:51];
    end
    if (adv) begin
      out_q <= res;
    end
  end

  scs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  scs_core #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.status, out_q.wdata_taken, out_q.rdata_valid,
                          out_q.rdata, out_q.cs_active, out_q.mosi};
  assign m_axis_tlast  = out_q.done_res;

  // back-pressure only comes from a full input stage
  `SCS_ASSERT_ALWAYS(a_ready_full, clk_i, !s_axis_tready |-> in_valid_q, "ready low with empty input stage")
  // every advanced item yields a result next cycle
  `SCS_ASSERT(a_adv_result, clk_i, rst_ni, adv |=> out_valid_q, "advanced item lost")
  // finishing deselects the card and idles the bus
  `SCS_ASSERT(a_done_idle, clk_i, rst_ni, (out_valid_q && out_q.done_res) |-> (!out_q.cs_active && out_q.mosi == ByteIdle), "done without deselect")
  // read data and write data never share a result
  `SCS_ASSERT(a_rd_wr_excl, clk_i, rst_ni, out_valid_q |-> !(out_q.rdata_valid && out_q.wdata_taken), "read and write flags together")
  // status only reported with completion
  `SCS_ASSERT(a_status_done, clk_i, rst_ni, (out_valid_q && !out_q.done_res) |-> (out_q.status == StOk), "status without done")

endmodule

// ----- rtl/scs_cfg.sv -----
// Configuration register file of the SPI card sector transfer block
module scs_cfg import scs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [1:0]  addr_i,
  input  logic [31:0] wdata_i,
  output scs_cfg_t    cfg_o
);

  scs_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (scs_cfg_idx_e'(addr_i))
        CfgNacLimit:    cfg_d.nac_limit    = wdata_i;
        CfgPollLimit:   cfg_d.poll_limit   = wdata_i[7:0];
        CfgResendLimit: cfg_d.resend_limit = wdata_i[7:0];
        CfgRetryLimit:  cfg_d.retry_limit  = wdata_i[3:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nac_limit    <= NacLimitRst;
      cfg_q.poll_limit   <= PollLimitRst;
      cfg_q.resend_limit <= ResendLimitRst;
      cfg_q.retry_limit  <= RetryLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/scs_core.sv -----
// Transfer sequencer: state registers and per-byte next-state logic
module scs_core import scs_pkg::*; #(
  parameter int SECTOR_BYTES = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  scs_item_t item_i,
  input  scs_cfg_t  cfg_i,
  output scs_res_t  res_o
);

  localparam int IdxW = $clog2(SECTOR_BYTES + 4);
  localparam int CmpW = (IdxW > 10) ? IdxW : 10;
  localparam logic [IdxW-1:0] FrmCmd   = IdxW'(1);
  localparam logic [IdxW-1:0] FrmAddr3 = IdxW'(2);
  localparam logic [IdxW-1:0] FrmAddr2 = IdxW'(3);
  localparam logic [IdxW-1:0] FrmAddr1 = IdxW'(4);
  localparam logic [IdxW-1:0] FrmAddr0 = IdxW'(5);
  localparam logic [IdxW-1:0] FrmCrc   = IdxW'(6);
  localparam logic [IdxW-1:0] DataEnd  = IdxW'(SECTOR_BYTES);
  localparam logic [IdxW-1:0] RdEnd    = IdxW'(SECTOR_BYTES + 2);
  localparam logic [IdxW-1:0] WrEnd    = IdxW'(SECTOR_BYTES + 3);

  typedef enum logic [3:0] {
    PhIdle  = 4'd0,
    PhCmd   = 4'd1,
    PhPoll  = 4'd2,
    PhToken = 4'd3,
    PhRdata = 4'd4,
    PhWgap  = 4'd5,
    PhWdata = 4'd6,
    PhWresp = 4'd7,
    PhBusy  = 4'd8
  } phase_e;

  phase_e            phase_d, phase_q;
  logic              is_write_d, is_write_q;
  logic [31:0]       byte_addr_d, byte_addr_q;
  logic [8:0]        win_start_d, win_start_q;
  logic [9:0]        win_len_d, win_len_q;
  logic [IdxW-1:0]   byte_idx_d, byte_idx_q;
  logic [31:0]       poll_cnt_d, poll_cnt_q;
  logic [7:0]        resend_cnt_d, resend_cnt_q;
  logic [3:0]        retry_cnt_d, retry_cnt_q;

  logic [31:0]       pc_inc;
  logic [IdxW-1:0]   idx_inc;
  logic [CmpW-1:0]   idx_ext, ws_ext, wl_ext;
  logic              in_win;
  logic              fail, restart;
  scs_status_e       fail_st;
  scs_res_t          res;

  assign pc_inc  = (poll_cnt_q == '1) ? poll_cnt_q : poll_cnt_q + 32'd1;
  assign idx_inc = byte_idx_q + IdxW'(1);
  assign idx_ext = CmpW'(byte_idx_q);
  assign ws_ext  = CmpW'(win_start_q);
  assign wl_ext  = CmpW'(win_len_q);
  assign in_win  = (idx_ext >= ws_ext) && ((idx_ext - ws_ext) < wl_ext);

  always_comb begin
    phase_d      = phase_q;
    is_write_d   = is_write_q;
    byte_addr_d  = byte_addr_q;
    win_start_d  = win_start_q;
    win_len_d    = win_len_q;
    byte_idx_d   = byte_idx_q;
    poll_cnt_d   = poll_cnt_q;
    resend_cnt_d = resend_cnt_q;
    retry_cnt_d  = retry_cnt_q;
    fail         = 1'b0;
    fail_st      = StOk;
    restart      = 1'b0;
    res          = '0;
    res.mosi     = ByteIdle;

    if (!item_i.kind) begin
      // new request drops whatever was running
      is_write_d   = item_i.write_op;
      byte_addr_d  = 32'(item_i.sector) * 32'(SECTOR_BYTES);
      win_start_d  = item_i.offset;
      win_len_d    = item_i.count;
      retry_cnt_d  = '0;
      resend_cnt_d = '0;
      restart      = 1'b1;
    end else begin
      unique case (phase_q)
        PhCmd: begin
          res.cs_active = 1'b1;
          if (byte_idx_q >= FrmCmd && byte_idx_q <= FrmCrc) begin
            if (byte_idx_q == FrmCmd) begin
              res.mosi = (is_write_q ? CmdWrite : CmdRead) | CmdFlag;
            end else if (byte_idx_q == FrmAddr3) begin
              res.mosi = byte_addr_q[31:24];
            end else if (byte_idx_q == FrmAddr2) begin
              res.mosi = byte_addr_q[23:16];
            end else if (byte_idx_q == FrmAddr1) begin
              res.mosi = byte_addr_q[15:8];
            end else if (byte_idx_q == FrmAddr0) begin
              res.mosi = byte_addr_q[7:0];
            end else begin
              res.mosi = CmdCrc;
            end
            byte_idx_d = idx_inc;
          end else begin
            phase_d    = PhPoll;
            poll_cnt_d = '0;
          end
        end
        PhPoll: begin
          poll_cnt_d = pc_inc;
          if (item_i.miso == ByteIdle && pc_inc < 32'(cfg_i.poll_limit)) begin
            res.cs_active = 1'b1;
          end else if (item_i.miso == R1Ready) begin
            phase_d       = is_write_q ? PhWgap : PhToken;
            poll_cnt_d    = '0;
            res.cs_active = 1'b1;
          end else if (9'(resend_cnt_q) + 9'd1 >= 9'(cfg_i.resend_limit)) begin
            fail    = 1'b1;
            fail_st = StCmdFail;
          end else begin
            resend_cnt_d = resend_cnt_q + 8'd1;
            restart      = 1'b1;
          end
        end
        PhToken: begin
          if (item_i.miso == TokenStart) begin
            phase_d       = PhRdata;
            byte_idx_d    = '0;
            res.cs_active = 1'b1;
          end else begin
            poll_cnt_d = pc_inc;
            if (pc_inc >= cfg_i.nac_limit) begin
              fail    = 1'b1;
              fail_st = StTokenTimeout;
            end else begin
              res.cs_active = 1'b1;
            end
          end
        end
        PhRdata: begin
          if (byte_idx_q < DataEnd && in_win) begin
            res.rdata       = item_i.miso;
            res.rdata_valid = 1'b1;
          end
          byte_idx_d = idx_inc;
          if (idx_inc >= RdEnd) begin
            phase_d      = PhIdle;
            res.done_res = 1'b1;
          end else begin
            res.cs_active = 1'b1;
          end
        end
        PhWgap: begin
          phase_d       = PhWdata;
          byte_idx_d    = '0;
          res.mosi      = TokenStart;
          res.cs_active = 1'b1;
        end
        PhWdata: begin
          res.cs_active = 1'b1;
          if (byte_idx_q < DataEnd) begin
            res.mosi        = item_i.wdata;
            res.wdata_taken = 1'b1;
          end
          byte_idx_d = idx_inc;
          if (idx_inc >= WrEnd) begin
            phase_d = PhWresp;
          end
        end
        PhWresp: begin
          if ((item_i.miso & DrespMask) == DrespOk) begin
            phase_d       = PhBusy;
            res.cs_active = 1'b1;
          end else begin
            fail    = 1'b1;
            fail_st = StWriteReject;
          end
        end
        PhBusy: begin
          if (item_i.miso != ByteIdle) begin
            res.cs_active = 1'b1;
          end else begin
            phase_d      = PhIdle;
            res.done_res = 1'b1;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end

    // failed attempt: report or start over
    if (fail) begin
      if (5'(retry_cnt_q) + 5'd1 >= 5'(cfg_i.retry_limit)) begin
        phase_d       = PhIdle;
        res.cs_active = 1'b0;
        res.done_res  = 1'b1;
        res.status    = fail_st;
      end else begin
        retry_cnt_d  = retry_cnt_q + 4'd1;
        resend_cnt_d = '0;
        restart      = 1'b1;
      end
    end

    // command frame opens with an idle byte, CS high
    if (restart) begin
      phase_d       = PhCmd;
      byte_idx_d    = FrmCmd;
      poll_cnt_d    = '0;
      res.mosi      = ByteIdle;
      res.cs_active = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      is_write_q   <= 1'b0;
      byte_addr_q  <= '0;
      win_start_q  <= '0;
      win_len_q    <= '0;
      byte_idx_q   <= '0;
      poll_cnt_q   <= '0;
      resend_cnt_q <= '0;
      retry_cnt_q  <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      is_write_q   <= is_write_d;
      byte_addr_q  <= byte_addr_d;
      win_start_q  <= win_start_d;
      win_len_q    <= win_len_d;
      byte_idx_q   <= byte_idx_d;
      poll_cnt_q   <= poll_cnt_d;
      resend_cnt_q <= resend_cnt_d;
      retry_cnt_q  <= retry_cnt_d;
    end
  end

  assign res_o = res;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the SPI card sector transfer engine
module testbench;
  import scs_pkg::*;

  localparam int          SectorBytes = 512;
  localparam int unsigned CycleLimit  = 1_000_000;
  // settle time after draining; each result passes the input and result registers
  localparam int          SettleCycles = 6;
  localparam int          HoldCycles   = 300;

  localparam logic KindRequest  = 1'b0;
  localparam logic KindExchange = 1'b1;

  // sequencer phases of the predictor
  typedef enum logic [3:0] {
    PhIdle, PhCmd, PhPoll, PhToken, PhRdata, PhWgap, PhWdata, PhWresp, PhBusy
  } card_phase_e;

  // Predicts one result per accepted input and checks results in order.
  class sector_xfer_scoreboard;
    logic [31:0]  nac_lim;
    logic [7:0]   poll_lim;
    logic [7:0]   resend_lim;
    logic [3:0]   retry_lim;
    card_phase_e  phase;
    logic         is_wr;
    logic [31:0]  byte_addr;
    logic [8:0]   win_start;
    logic [9:0]   win_len;
    int unsigned  byte_idx;
    logic [31:0]  poll_cnt;
    logic [7:0]   resend_cnt;
    logic [3:0]   retry_cnt;
    scs_res_t     nxt;
    scs_res_t     pending[$];
    int unsigned  errors;

    function new();
      nac_lim = NacLimitRst;
      poll_lim = PollLimitRst;
      resend_lim = ResendLimitRst;
      retry_lim = RetryLimitRst;
      phase = PhIdle;
      is_wr = 1'b0;
      byte_addr = '0;
      win_start = '0;
      win_len = '0;
      byte_idx = 0;
      poll_cnt = '0;
      resend_cnt = '0;
      retry_cnt = '0;
      errors = 0;
    endfunction

    function void set_limit(scs_cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CfgNacLimit:    nac_lim = val;
        CfgPollLimit:   poll_lim = val[7:0];
        CfgResendLimit: resend_lim = val[7:0];
        CfgRetryLimit:  retry_lim = val[3:0];
      endcase
    endfunction

    function void put(logic [7:0] mosi, logic cs);
      nxt.mosi = mosi;
      nxt.cs_active = cs;
    endfunction

    function void open_frame();
      phase = PhCmd;
      byte_idx = 1;
      poll_cnt = '0;
      put(ByteIdle, 1'b0);
    endfunction

    function void close(scs_status_e st);
      phase = PhIdle;
      put(ByteIdle, 1'b0);
      nxt.done_res = 1'b1;
      nxt.status = st;
    endfunction

    function void attempt_failed(scs_status_e st);
      if (32'(retry_cnt) + 32'd1 >= 32'(retry_lim)) begin
        close(st);
        return;
      end
      retry_cnt++;
      resend_cnt = '0;
      open_frame();
    endfunction

    function void note_item(scs_item_t it);
      logic [7:0] cmd_byte;
      nxt = '0;
      if (it.kind == KindRequest) begin
        is_wr = it.write_op;
        byte_addr = 32'(it.sector) * SectorBytes;
        win_start = it.offset;
        win_len = it.count;
        retry_cnt = '0;
        resend_cnt = '0;
        open_frame();
        pending.push_back(nxt);
        return;
      end
      case (phase)
        PhCmd: begin
          if (byte_idx >= 1 && byte_idx <= 6) begin
            case (byte_idx)
              1:       cmd_byte = (is_wr ? CmdWrite : CmdRead) | CmdFlag;
              6:       cmd_byte = CmdCrc;
              default: cmd_byte = 8'(byte_addr >> ((5 - byte_idx) * 8));
            endcase
            put(cmd_byte, 1'b1);
            byte_idx++;
          end else begin
            phase = PhPoll;
            poll_cnt = '0;
            put(ByteIdle, 1'b1);
          end
        end
        PhPoll: begin
          if (poll_cnt != '1) poll_cnt++;
          if (it.miso == ByteIdle && poll_cnt < 32'(poll_lim)) begin
            put(ByteIdle, 1'b1);
          end else if (it.miso == R1Ready) begin
            phase = is_wr ? PhWgap : PhToken;
            poll_cnt = '0;
            put(ByteIdle, 1'b1);
          end else if (32'(resend_cnt) + 32'd1 >= 32'(resend_lim)) begin
            attempt_failed(StCmdFail);
          end else begin
            resend_cnt++;
            open_frame();
          end
        end
        PhToken: begin
          if (it.miso == TokenStart) begin
            phase = PhRdata;
            byte_idx = 0;
            put(ByteIdle, 1'b1);
          end else begin
            if (poll_cnt != '1) poll_cnt++;
            if (poll_cnt >= nac_lim) attempt_failed(StTokenTimeout);
            else put(ByteIdle, 1'b1);
          end
        end
        PhRdata: begin
          if (byte_idx < SectorBytes && byte_idx >= win_start &&
              byte_idx - win_start < win_len) begin
            nxt.rdata = it.miso;
            nxt.rdata_valid = 1'b1;
          end
          byte_idx++;
          if (byte_idx >= SectorBytes + 2) close(StOk);
          else put(ByteIdle, 1'b1);
        end
        PhWgap: begin
          phase = PhWdata;
          byte_idx = 0;
          put(TokenStart, 1'b1);
        end
        PhWdata: begin
          if (byte_idx < SectorBytes) begin
            put(it.wdata, 1'b1);
            nxt.wdata_taken = 1'b1;
          end else begin
            put(ByteIdle, 1'b1);
          end
          byte_idx++;
          if (byte_idx >= SectorBytes + 3) phase = PhWresp;
        end
        PhWresp: begin
          if ((it.miso & DrespMask) == DrespOk) begin
            phase = PhBusy;
            put(ByteIdle, 1'b1);
          end else begin
            attempt_failed(StWriteReject);
          end
        end
        PhBusy: begin
          if (it.miso != ByteIdle) put(ByteIdle, 1'b1);
          else close(StOk);
        end
        default: begin
          phase = PhIdle;
          put(ByteIdle, 1'b0);
        end
      endcase
      pending.push_back(nxt);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [23:0] data, logic last);
      scs_res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h last %0b",
                 $time, data, last);
        return;
      end
      want = pending.pop_front();
      compare_field("mosi", want.mosi, data[7:0]);
      compare_field("cs_active", 8'(want.cs_active), 8'(data[8]));
      compare_field("rdata", want.rdata, data[16:9]);
      compare_field("rdata_valid", 8'(want.rdata_valid), 8'(data[17]));
      compare_field("wdata_taken", 8'(want.wdata_taken), 8'(data[18]));
      compare_field("done_res", 8'(want.done_res), 8'(last));
      compare_field("status", 8'(want.status), 8'(data[20:19]));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block under test
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // write_op, sector, offset, count, miso, wdata, zero
  logic        s_axis_tuser = 1'b0; // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // mosi, cs_active, rdata, rdata_valid, wdata_taken, status
  logic        m_axis_tlast;        // done_res
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = CfgNacLimit;
  logic [31:0] cfg_wdata_i = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  spi_card_sector_transfer #(.SECTOR_BYTES(SectorBytes)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  sector_xfer_scoreboard sb = new();

  int unsigned cycle_cnt = 0;
  int unsigned tx_count = 0;
  bit          tx_quiet = 1'b0;   // stretches where the sender never idles
  int unsigned xfer_no = 0;       // alternates read and write transfers

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  // Request with a bias toward the window extremes; a window running past the
  // end of the sector shows up often this way.
  function automatic scs_item_t request_item(logic wr);
    scs_item_t it;
    int unsigned pick;
    it.kind = KindRequest;
    it.write_op = wr;
    pick = $urandom_range(0, 3);
    it.sector = pick == 0 ? '0 : pick == 1 ? '1 : 23'($urandom);
    pick = $urandom_range(0, 3);
    it.offset = pick == 0 ? '0 : pick == 1 ? '1 : 9'($urandom);
    pick = $urandom_range(0, 3);
    it.count = pick == 0 ? '0 : pick == 1 ? 10'(SectorBytes) : 10'($urandom_range(0, 512));
    it.miso = 8'($urandom);
    it.wdata = 8'($urandom);
    return it;
  endfunction

  // Exchange; request-only fields carry random junk that the block must ignore.
  function automatic scs_item_t exchange_item(logic [7:0] miso);
    scs_item_t it;
    it.kind = KindExchange;
    it.write_op = 1'($urandom);
    it.sector = 23'($urandom);
    it.offset = 9'($urandom);
    it.count = 10'($urandom_range(0, 512));
    it.miso = miso;
    it.wdata = 8'($urandom);
    return it;
  endfunction

  // Card side: answers what the engine is currently waiting for, mostly
  // well-behaved, with enough bad answers to drive resends, timeouts and rejects.
  function automatic logic [7:0] card_reply();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (sb.phase)
      PhPoll:  return r < 50 ? R1Ready : r < 85 ? ByteIdle : 8'($urandom);
      PhToken: return r < 30 ? TokenStart : r < 90 ? ByteIdle : 8'($urandom);
      PhWresp: return r < 80 ? {3'($urandom), DrespOk[4:0]} : 8'($urandom);
      PhBusy:  return r < 30 ? ByteIdle : 8'($urandom_range(0, 254));
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One input transfer; the prediction is made at the accepting edge.
  task automatic push_item(input scs_item_t it);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {5'b0, it.wdata, it.miso, it.count, it.offset, it.sector, it.write_op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
    tx_count++;
    if (tx_count % 120 == 0) tx_quiet = !tx_quiet;
  endtask

  // Stop offering and let every predicted result drain out of the block.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Back-to-back writes of all four limits while the block is empty.
  task automatic write_limits(input logic [31:0] nac, input logic [7:0] poll,
                              input logic [7:0] resend, input logic [3:0] retry);
    logic [31:0] val [4];
    wait_drained();
    val = '{nac, 32'(poll), 32'(resend), 32'(retry)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_addr_i <= scs_cfg_idx_e'(i);
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      sb.set_limit(scs_cfg_idx_e'(i), val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Whole transfers with card answers; some are cut short once by a new request,
  // and now and then an exchange arrives with nothing in progress.
  task automatic run_phase(input int n);
    int  moved;
    bit  noisy;
    moved = 0;
    while (moved < n) begin
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 3)) push_item(exchange_item(8'($urandom)));
      noisy = $urandom_range(0, 4) == 0;
      push_item(request_item(xfer_no[0]));
      xfer_no++;
      moved++;
      do begin
        if (noisy && $urandom_range(0, 49) == 0) begin
          push_item(request_item(1'($urandom)));
          noisy = 1'b0;
        end else begin
          push_item(exchange_item(card_reply()));
        end
        moved++;
      end while (sb.phase != PhIdle);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per result, quiet stretches, and two long
  // hold-offs so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int          stall;
    int unsigned seen;
    bit          rx_quiet;
    seen = 0;
    rx_quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 10);
      if (seen == 300 || seen == 1500) stall = HoldCycles;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tlast);
      seen++;
      if (seen % 150 == 0) rx_quiet = !rx_quiet;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    scs_item_t it;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // exchange with nothing in progress
    push_item(exchange_item(ByteIdle));
    // write at the top sector with the largest offset and count, cut off mid-frame
    it = request_item(1'b1);
    it.sector = '1;
    it.offset = '1;
    it.count = 10'(SectorBytes);
    push_item(it);
    repeat (4) push_item(exchange_item(8'h00));
    // new request while busy: read sector 0 with an empty window
    it = request_item(1'b0);
    it.sector = '0;
    it.offset = '0;
    it.count = '0;
    push_item(it);
    repeat (7) push_item(exchange_item(ByteIdle));
    // bad R1 forces a frame resend, then the poll succeeds
    push_item(exchange_item(8'h01));
    repeat (8) push_item(exchange_item(ByteIdle));
    push_item(exchange_item(R1Ready));

    // reset limits; one full sector transfer already covers the budget
    run_phase(200);
    // smallest legal limits: every failure path at its first chance
    write_limits(32'd1, 8'd1, 8'd1, 4'd1);
    run_phase(150);
    // small random limits: resends, retries and each failure status
    write_limits(32'($urandom_range(1, 12)), 8'($urandom_range(1, 6)),
                 8'($urandom_range(1, 4)), 4'($urandom_range(2, 4)));
    run_phase(200);
    // zero limits behave as one
    write_limits('0, '0, '0, '0);
    run_phase(100);
    // largest limits
    write_limits('1, 8'd255, 8'd255, 4'd15);
    run_phase(200);

    wait_drained();
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
